// ----- sv/hv_charger_negotiation_fsm_macros.svh -----
// Assertion macros for the high-voltage charger negotiation controller.
// Needs nothing else; the asserting module includes this by bare file name.
`ifndef HV_CHARGER_NEGOTIATION_FSM_MACROS_SVH
`define HV_CHARGER_NEGOTIATION_FSM_MACROS_SVH

`ifndef SYNTHESIS
// Clocked property that is switched off while reset is high.
`define HVCN_ASSERT_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("hvcn assertion failed");
// Clocked property that is checked also during reset.
`define HVCN_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("hvcn assertion failed");
`else
`define HVCN_ASSERT_RST(label, clk, rst, prop)
`define HVCN_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ----- sv/hvcn_pkg.sv -----
// Types, codes and reset constants for the high-voltage charger negotiation controller.
// Self-contained; used by hv_charger_negotiation_fsm.
package hvcn_pkg;

   // Status sample carried by one input transfer
   typedef struct packed {
      logic        adapter_detected;
      logic [14:0] bus_voltage_mv;
      logic        current_limited;
   } req_type;

   // One result per tick
   typedef struct packed {
      logic [2:0] action;
      logic [4:0] burst_length;
      logic [4:0] pulse_total;
      logic [3:0] phase;
   } rsp_type;

   // Action codes
   localparam logic [2:0] ACT_NONE      = 3'd0;
   localparam logic [2:0] ACT_PREPARE   = 3'd1;
   localparam logic [2:0] ACT_BURST     = 3'd2;
   localparam logic [2:0] ACT_CONFIRMED = 3'd3;
   localparam logic [2:0] ACT_RERUN     = 3'd4;
   localparam logic [2:0] ACT_DP        = 3'd5;
   localparam logic [2:0] ACT_DM        = 3'd6;

   // Configuration register indexes
   localparam logic [1:0] CSR_CONFIRM_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_MAX_PULSE_STEPS   = 2'd1;
   localparam logic [1:0] CSR_AUTH_PULSE_COUNT  = 2'd2;

   // Register reset values
   localparam logic [14:0] CONFIRM_THRESHOLD_RST = 15'd6000;
   localparam logic [4:0]  MAX_PULSE_STEPS_RST   = 5'd20;
   localparam logic [4:0]  AUTH_PULSE_COUNT_RST  = 5'd6;

   // Controller states, one-hot
   typedef enum logic [9:0] {
      PH_IDLE    = 10'b00_0000_0001,
      PH_PREPARE = 10'b00_0000_0010,
      PH_AUTH    = 10'b00_0000_0100,
      PH_CONFIRM = 10'b00_0000_1000,
      PH_INITVOL = 10'b00_0001_0000,
      PH_RERUN   = 10'b00_0010_0000,
      PH_NOTLIM  = 10'b00_0100_0000,
      PH_DP      = 10'b00_1000_0000,
      PH_LIMITED = 10'b01_0000_0000,
      PH_DM      = 10'b10_0000_0000
   } phase_type;

   // Sequence number of a state as reported on the result channel
   function automatic logic [3:0] phase_code(input phase_type ph);
      logic [3:0] code;
      case (ph)
         PH_IDLE:    code = 4'd0;
         PH_PREPARE: code = 4'd1;
         PH_AUTH:    code = 4'd2;
         PH_CONFIRM: code = 4'd3;
         PH_INITVOL: code = 4'd4;
         PH_RERUN:   code = 4'd5;
         PH_NOTLIM:  code = 4'd6;
         PH_DP:      code = 4'd7;
         PH_LIMITED: code = 4'd8;
         PH_DM:      code = 4'd9;
         default:    code = 4'd0;
      endcase
      return code;
   endfunction

endpackage

// ----- sv/hv_charger_negotiation_fsm.sv -----
// Top level of the high-voltage charger negotiation controller.
// Depends on hvcn_pkg and hv_charger_negotiation_fsm_macros.svh.
// The result of a tick is registered and is on rsp_* in the cycle after its transfer.
// Throughput: one tick per cycle while rsp_ready is high, set by a single pass of compare and counter logic.
// Reset (synchronous, active high): state idle, pulse counter 0, registers at
// their defaults, no result pending.
`include "hv_charger_negotiation_fsm_macros.svh"

module hv_charger_negotiation_fsm
   import hvcn_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // status ticks
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   // results
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [14:0] csr_data
);

   // Configuration registers
   logic [14:0] confirm_threshold_ff;
   logic [4:0]  max_pulse_steps_ff;
   logic [4:0]  auth_pulse_count_ff;

   // Controller state
   phase_type   phase_ff, phase_in;
   logic [4:0]  pulse_ff, pulse_in;

   // Result register
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic        req_fire;
   logic [2:0]  action;
   logic [4:0]  burst;

   // Configuration writes are always taken
   assign csr_ready = 1'b1;

   // Accept a new tick whenever the result register is empty or being drained
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Next state, counter and action for the tick on the input
   always_comb begin
      phase_in = PH_IDLE;
      pulse_in = pulse_ff;
      action   = ACT_NONE;
      burst    = '0;
      if (!req_data.adapter_detected) begin
         // adapter gone: drop back to idle whatever the state
         pulse_in = '0;
      end else begin
         case (phase_ff)
            PH_IDLE: begin
               pulse_in = '0;
               phase_in = PH_PREPARE;
            end
            PH_PREPARE: begin
               action   = ACT_PREPARE;
               phase_in = PH_AUTH;
            end
            PH_AUTH: begin
               action   = ACT_BURST;
               burst    = auth_pulse_count_ff;
               pulse_in = auth_pulse_count_ff;
               phase_in = PH_CONFIRM;
            end
            PH_CONFIRM: begin
               if (req_data.bus_voltage_mv >= confirm_threshold_ff) begin
                  action   = ACT_CONFIRMED;
                  phase_in = PH_INITVOL;
               end else begin
                  // authentication not confirmed: start over
                  pulse_in = '0;
               end
            end
            PH_INITVOL: begin
               phase_in = PH_RERUN;
            end
            PH_RERUN: begin
               action   = ACT_RERUN;
               phase_in = req_data.current_limited ? PH_LIMITED : PH_NOTLIM;
            end
            PH_NOTLIM: begin
               phase_in = req_data.current_limited ? PH_LIMITED : PH_DM;
            end
            PH_DP: begin
               // raise one step unless already at the ceiling
               if (pulse_ff < max_pulse_steps_ff) begin
                  action   = ACT_DP;
                  pulse_in = pulse_ff + 5'd1;
               end
               phase_in = req_data.current_limited ? PH_DP : PH_RERUN;
            end
            PH_LIMITED: begin
               phase_in = req_data.current_limited ? PH_DP : PH_RERUN;
            end
            PH_DM: begin
               // lower one step unless already at zero
               if (pulse_ff != 5'd0) begin
                  action   = ACT_DM;
                  pulse_in = pulse_ff - 5'd1;
               end
               phase_in = req_data.current_limited ? PH_LIMITED : PH_RERUN;
            end
            default: begin
               pulse_in = '0;
            end
         endcase
      end

      rsp_data_in.action       = action;
      rsp_data_in.burst_length = burst;
      rsp_data_in.pulse_total  = pulse_in;
      rsp_data_in.phase        = phase_code(phase_in);
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         confirm_threshold_ff <= CONFIRM_THRESHOLD_RST;
         max_pulse_steps_ff   <= MAX_PULSE_STEPS_RST;
         auth_pulse_count_ff  <= AUTH_PULSE_COUNT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CONFIRM_THRESHOLD: confirm_threshold_ff <= csr_data;
            CSR_MAX_PULSE_STEPS:   max_pulse_steps_ff   <= csr_data[4:0];
            CSR_AUTH_PULSE_COUNT:  auth_pulse_count_ff  <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   // Controller state advances once per transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         pulse_ff <= '0;
      end else if (req_fire) begin
         phase_ff <= phase_in;
         pulse_ff <= pulse_in;
      end
   end

   // Result register: load on transfer in, clear on transfer out
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // The reported phase follows the state register after every transfer
   `HVCN_ASSERT_RST(a_phase_matches, clock, reset,
      req_fire |=> rsp_data_ff.phase == phase_code(phase_ff))
   // The pulse counter reported is the one held for the next tick
   `HVCN_ASSERT_RST(a_pulse_matches, clock, reset,
      req_fire |=> rsp_data_ff.pulse_total == pulse_ff)
   // Losing the adapter clears the counter and returns to idle
   `HVCN_ASSERT_RST(a_adapter_lost, clock, reset,
      req_fire && !req_data.adapter_detected |=> pulse_ff == 5'd0 && phase_ff == PH_IDLE)
   // A D+ step never takes the counter past the ceiling
   `HVCN_ASSERT_RST(a_dp_bound, clock, reset,
      req_fire && action == ACT_DP |-> pulse_in <= max_pulse_steps_ff)
   // A pending result that is not taken blocks new ticks
   `HVCN_ASSERT_ALWAYS(a_backpressure, clock,
      rsp_valid_ff && !rsp_ready |-> !req_ready)

endmodule

// ----- sim/tb_top.sv -----
// Self-checking bench for hv_charger_negotiation_fsm: status ticks in, one action per tick out.
// Needs hvcn_pkg and the RTL top; an internal mirror of the negotiation sequence predicts results.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import hvcn_pkg::*;

   // Sequence numbers reported on rsp_data.phase
   typedef enum logic [3:0] {
      ST_IDLE    = 4'd0,
      ST_PREPARE = 4'd1,
      ST_AUTH    = 4'd2,
      ST_CONFIRM = 4'd3,
      ST_INITVOL = 4'd4,
      ST_RERUN   = 4'd5,
      ST_NOTLIM  = 4'd6,
      ST_DP      = 4'd7,
      ST_LIMITED = 4'd8,
      ST_DM      = 4'd9
   } seq_phase_type;

   localparam int QUIET_LIMIT  = 2000;
   localparam int RANDOM_TICKS = 330;
   localparam int NUM_SETTINGS = 6;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_CONFIRM_THRESHOLD;
   logic [14:0] csr_data = '0;

   hv_charger_negotiation_fsm u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Ticks waiting to be driven, and the actions predicted for accepted ticks
   req_type     tick_queue[$];
   rsp_type     predicted_rsp[$];

   // Mirror of the controller: state, counter and register copies
   seq_phase_type ph_now;
   logic [4:0]  cnt_now;
   logic [14:0] conf_thr;
   logic [4:0]  conf_max;
   logic [4:0]  conf_auth;

   // Idling percentages, changed by the stimulus thread
   int unsigned tx_idle_pct = 25;
   int unsigned rx_stall_pct = 57;

   int n_sent = 0;
   int n_results = 0;
   int n_fail = 0;
   int n_dp = 0;
   int n_dm = 0;
   int n_at_bound = 0;
   int n_at_zero = 0;
   int n_confirm_fail = 0;
   int quiet_cycles = 0;

   // Setting table; the first row is the reset state and is never written
   int cfg_thr[NUM_SETTINGS]  = '{6000, 0, 20000, 0, 12000, 3000};
   int cfg_max[NUM_SETTINGS]  = '{20, 31, 0, 0, 31, 5};
   int cfg_auth[NUM_SETTINGS] = '{6, 31, 0, 0, 0, 25};

   initial begin
      forever #1 clock = ~clock;
   end

   // Advance the mirror by one tick and return the action it should produce
   function automatic rsp_type step_charger(input req_type t);
      rsp_type       r;
      seq_phase_type nxt;
      r = '0;
      r.action = ACT_NONE;
      nxt = ST_IDLE;
      if (!t.adapter_detected) begin
         // adapter lost: drop to idle from anywhere
         cnt_now = '0;
      end else begin
         case (ph_now)
            ST_IDLE: begin
               cnt_now = '0;
               nxt = ST_PREPARE;
            end
            ST_PREPARE: begin
               r.action = ACT_PREPARE;
               nxt = ST_AUTH;
            end
            ST_AUTH: begin
               r.action = ACT_BURST;
               r.burst_length = conf_auth;
               cnt_now = conf_auth;
               nxt = ST_CONFIRM;
            end
            ST_CONFIRM: begin
               if (t.bus_voltage_mv >= conf_thr) begin
                  r.action = ACT_CONFIRMED;
                  nxt = ST_INITVOL;
               end else begin
                  cnt_now = '0;
                  n_confirm_fail++;
               end
            end
            ST_INITVOL: nxt = ST_RERUN;
            ST_RERUN: begin
               r.action = ACT_RERUN;
               nxt = t.current_limited ? ST_LIMITED : ST_NOTLIM;
            end
            ST_NOTLIM: nxt = t.current_limited ? ST_LIMITED : ST_DM;
            ST_DP: begin
               if (cnt_now < conf_max) begin
                  r.action = ACT_DP;
                  cnt_now = cnt_now + 5'd1;
                  n_dp++;
               end else begin
                  n_at_bound++;
               end
               nxt = t.current_limited ? ST_DP : ST_RERUN;
            end
            ST_LIMITED: nxt = t.current_limited ? ST_DP : ST_RERUN;
            ST_DM: begin
               if (cnt_now > 5'd0) begin
                  r.action = ACT_DM;
                  cnt_now = cnt_now - 5'd1;
                  n_dm++;
               end else begin
                  n_at_zero++;
               end
               nxt = t.current_limited ? ST_LIMITED : ST_RERUN;
            end
            default: cnt_now = '0;
         endcase
      end
      ph_now = nxt;
      r.pulse_total = cnt_now;
      r.phase = nxt;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [14:0] want,
                              input logic [14:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
         n_fail++;
      end
   endtask

   // Driver: present the next tick once the previous one has transferred
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (tick_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
            req_data  <= tick_queue.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: mirror register writes, predict on each tick transfer, check each
   // result transfer against the oldest prediction, and guard against a hang
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         ph_now    = ST_IDLE;
         cnt_now   = '0;
         conf_thr  = CONFIRM_THRESHOLD_RST;
         conf_max  = MAX_PULSE_STEPS_RST;
         conf_auth = AUTH_PULSE_COUNT_RST;
         predicted_rsp.delete();
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_stall_pct);

         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CONFIRM_THRESHOLD: conf_thr  = csr_data;
               CSR_MAX_PULSE_STEPS:   conf_max  = csr_data[4:0];
               CSR_AUTH_PULSE_COUNT:  conf_auth = csr_data[4:0];
               default: ;
            endcase
         end

         // predict first, so a result in the same cycle would still find its entry
         if (req_valid && req_ready)
            predicted_rsp.push_back(step_charger(req_data));

         if (rsp_valid && rsp_ready) begin
            n_results++;
            if (predicted_rsp.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $realtime,
                        rsp_data);
               n_fail++;
            end else begin
               check_field("action", 15'(predicted_rsp[0].action), 15'(rsp_data.action));
               check_field("burst_length", 15'(predicted_rsp[0].burst_length),
                           15'(rsp_data.burst_length));
               check_field("pulse_total", 15'(predicted_rsp[0].pulse_total),
                           15'(rsp_data.pulse_total));
               check_field("phase", 15'(predicted_rsp[0].phase), 15'(rsp_data.phase));
               void'(predicted_rsp.pop_front());
            end
         end

         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $realtime, QUIET_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   task automatic push_tick(input logic det, input int mv, input logic lim);
      req_type t;
      t.adapter_detected = det;
      t.bus_voltage_mv   = mv[14:0];
      t.current_limited  = lim;
      tick_queue.push_back(t);
      n_sent++;
   endtask

   // Mostly whole sessions from idle with sticky limit runs; the rest is noise
   // and sessions broken by brief adapter dropouts
   task automatic gen_traffic(input int count, input int thr);
      int   made;
      int   len;
      int   flip_pct;
      int   mv;
      logic lim;
      made = 0;
      while (made < count) begin
         if ($urandom_range(99) < 10) begin
            push_tick(1'($urandom_range(1)), int'($urandom_range(20000)),
                      1'($urandom_range(1)));
            made++;
         end else begin
            len = ($urandom_range(9) == 0) ? $urandom_range(200, 100) : $urandom_range(60, 6);
            flip_pct = $urandom_range(30, 2);
            lim = 1'($urandom_range(1));
            // start from idle
            push_tick(1'b0, int'($urandom_range(20000)), 1'($urandom_range(1)));
            made++;
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(99) < flip_pct)
                  lim = ~lim;
               // fourth tick of the session lands on the voltage confirm
               if (i == 3)
                  mv = ($urandom_range(99) < 85 || thr == 0) ? $urandom_range(20000, thr)
                                                             : $urandom_range(thr - 1);
               else
                  mv = $urandom_range(20000);
               push_tick($urandom_range(99) >= 2, mv, lim);
               made++;
            end
         end
      end
   endtask

   // Hold until every tick sent so far has its result, then let the pipe settle
   task automatic wait_drained();
      do @(posedge clock); while (n_results < n_sent);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input int val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val[14:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      cfg_thr[3]  = $urandom_range(20000);
      cfg_max[3]  = $urandom_range(31);
      cfg_auth[3] = $urandom_range(31);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed walk through every state and most transitions at reset settings
      push_tick(1'b0, 0, 1'b0);       // idle, no adapter
      push_tick(1'b1, 20000, 1'b1);   // idle to prepare
      push_tick(1'b1, 0, 1'b0);       // prepare
      push_tick(1'b1, 0, 1'b1);       // authentication burst
      push_tick(1'b1, 5999, 1'b0);    // confirm just below threshold fails
      push_tick(1'b1, 0, 1'b0);
      push_tick(1'b1, 0, 1'b0);
      push_tick(1'b1, 0, 1'b0);
      push_tick(1'b1, 6000, 1'b0);    // confirm exactly at threshold
      push_tick(1'b1, 0, 1'b1);       // initial voltage straight to rerun
      push_tick(1'b1, 0, 1'b1);       // rerun, limited
      push_tick(1'b1, 0, 1'b1);       // limited to D+
      push_tick(1'b1, 0, 1'b1);       // raise, stay in D+
      push_tick(1'b1, 0, 1'b0);       // raise, back to rerun
      push_tick(1'b1, 0, 1'b0);       // rerun, not limited
      push_tick(1'b1, 0, 1'b1);       // not limited turns limited
      push_tick(1'b1, 0, 1'b0);       // limited back to rerun
      push_tick(1'b1, 0, 1'b0);
      push_tick(1'b1, 0, 1'b0);       // not limited to D-
      push_tick(1'b1, 0, 1'b1);       // lower, then limited
      push_tick(1'b0, 20000, 1'b1);   // adapter lost mid-sequence
      push_tick(1'b0, 0, 1'b0);

      for (int s = 0; s < NUM_SETTINGS; s++) begin
         // sender idles lightly first, then heavily, then neither side idles
         case (s / 2)
            0: begin
               tx_idle_pct = 25;
               rx_stall_pct = 57;
            end
            1: begin
               tx_idle_pct = 57;
               rx_stall_pct = 25;
            end
            default: begin
               tx_idle_pct = 0;
               rx_stall_pct = 0;
            end
         endcase
         if (s != 0) begin
            wait_drained();
            write_csr(CSR_CONFIRM_THRESHOLD, cfg_thr[s]);
            write_csr(CSR_MAX_PULSE_STEPS, cfg_max[s]);
            write_csr(CSR_AUTH_PULSE_COUNT, cfg_auth[s]);
         end
         gen_traffic(RANDOM_TICKS, cfg_thr[s]);
      end

      wait_drained();
      repeat (10) @(posedge clock);

      if (predicted_rsp.size() != 0) begin
         $display("%0t: %0d predicted results never arrived", $realtime, predicted_rsp.size());
         n_fail++;
      end

      $display("Run: %0d ticks over %0d register settings, %0d results checked, %0d mismatches.",
               n_sent, NUM_SETTINGS, n_results, n_fail);
      $display("Seen: %0d D+ and %0d D- pulses, %0d raises held at bound, %0d lowers at zero,",
               n_dp, n_dm, n_at_bound, n_at_zero);
      $display("      %0d failed confirms.", n_confirm_fail);
      if (n_fail == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- hv_charger_negotiation_fsm.f -----
+incdir+sv
sv/hvcn_pkg.sv
sv/hv_charger_negotiation_fsm.sv
sim/tb_top.sv
